// ===== rtl/dvru_pkg.sv =====
// dvru_pkg: shared constants for the distance-vector route engine
// holds the default node count, request mode codes, status codes and the unreachable cost; no dependencies
package dvru_pkg;

  localparam int NODES_DEF = 8;

  localparam logic [15:0] UNREACH = 16'hFFFF;

  localparam logic [1:0] MODE_SET = 2'd0;
  localparam logic [1:0] MODE_DIS = 2'd1;
  localparam logic [1:0] MODE_VEC = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SELF = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

endpackage

// ===== rtl/distance_vector_route_update.sv =====
// distance_vector_route_update: distance-vector route table with min-plus relaxation
// depends on dvru_pkg for mode codes, status codes and the unreachable cost
//
// A set-link request (mode 0) or a disable-self request is answered with one
// registered result; it is taken only when the output register is free.
// A vector entry request (mode 2) without the last flag is taken and gives
// no result. Any other disable request and the last entry of a vector start
// a route recompute that ends in NODES results, one per table slot, in slot
// order, final_res set on the last one. The recompute runs on one shared
// adder and a row of compares under a small sequencer: it seeds the routes
// from the direct costs, then for each active vector, own or stored, it looks
// up the cost to the sender and relaxes the vector entries one after another.
// A stored vector is first copied from the staging registers into the vector
// memory. The vector memory's single read port sets the pace of the
// relaxation. No new request is taken while a recompute or its results are
// pending.
module distance_vector_route_update #(
  parameter int NODES = dvru_pkg::NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: own node id
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_own_id,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_slot,
  input  logic [7:0]  in_node_id,
  input  logic [15:0] in_cost,
  input  logic        in_neighbor,
  input  logic        in_last,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_dest_id,
  output logic [15:0] out_route_cost,
  output logic [7:0]  out_next_hop,
  output logic        out_final_res
);

  localparam int STORE = NODES - 1;
  localparam int J_W   = $clog2(NODES);
  localparam int K_W   = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int C_W   = $clog2(NODES + 1);
  localparam int M_W   = K_W + J_W;
  localparam int MEM_DEPTH = 1 << M_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_COMMIT = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_INIT   = 3'd3;
  localparam logic [2:0] S_VIA    = 3'd4;
  localparam logic [2:0] S_REL    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  // node table, route table and staging registers
  logic [NODES-1:0][7:0]  ids_r, ids_nxt;
  logic [NODES-1:0][15:0] dcost_r, dcost_nxt;
  logic [NODES-1:0]       nbr_r, nbr_nxt;
  logic [NODES-1:0]       dis_r, dis_nxt;
  logic [NODES-1:0][15:0] rcost_r, rcost_nxt;
  logic [NODES-1:0][7:0]  nhop_r, nhop_nxt;
  logic [STORE-1:0]       svalid_r, svalid_nxt;
  logic [STORE-1:0][7:0]  ssender_r, ssender_nxt;
  logic [NODES-1:0][7:0]  stg_id_r, stg_id_nxt;
  logic [NODES-1:0][15:0] stg_cost_r, stg_cost_nxt;
  logic [C_W-1:0]         stg_cnt_r, stg_cnt_nxt;
  logic [7:0]             stg_snd_r, stg_snd_nxt;

  logic [7:0]     own_id_r, own_id_nxt;
  logic [2:0]     state_r, state_nxt;
  logic [J_W-1:0] cnt_r, cnt_nxt;     // entry, copy and emit counter
  logic [J_W-1:0] vsel_r, vsel_nxt;   // 0: own vector, k+1: stored vector k
  logic [K_W-1:0] dst_r, dst_nxt;
  logic [1:0]     st_r, st_nxt;
  logic [15:0]    via_r, via_nxt;
  logic [7:0]     snd_r, snd_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [1:0]  o_st_r, o_st_nxt;
  logic [7:0]  o_dest_r, o_dest_nxt;
  logic [15:0] o_cost_r, o_cost_nxt;
  logic [7:0]  o_nh_r, o_nh_nxt;
  logic        o_fin_r, o_fin_nxt;

  // stored vector memory, addressed {store slot, entry}
  logic [7:0]     mem_id [MEM_DEPTH];
  logic [15:0]    mem_cost [MEM_DEPTH];
  logic [7:0]     mem_id_q_r;
  logic [15:0]    mem_cost_q_r;
  logic           mem_we;
  logic [M_W-1:0] mem_waddr, mem_raddr;

  function automatic logic node_dis(input logic [7:0] id,
                                    input logic [NODES-1:0][7:0] ids,
                                    input logic [NODES-1:0] dis);
    logic r;
    r = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      if (ids[i] == id && dis[i]) r = 1'b1;
    end
    return r;
  endfunction

  logic           out_free;
  logic [K_W-1:0] vk;
  logic           dis_snd, dis_own, dis_vec;
  logic           hit, free;
  logic [K_W-1:0] hit_idx, free_idx;
  logic [7:0]     vec_snd;
  logic           vec_act;
  logic [15:0]    via_c;
  logic [7:0]     e_id;
  logic [15:0]    e_cost;
  logic [16:0]    sum;
  logic [J_W-1:0] slot_idx;
  logic [J_W-1:0] stg_idx;

  assign out_free  = !ov_r || out_ready;
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE) && out_free;

  assign vk       = K_W'(vsel_r - J_W'(1));
  assign dis_snd  = node_dis(stg_snd_r, ids_r, dis_r);
  assign dis_own  = node_dis(own_id_r, ids_r, dis_r);
  assign vec_snd  = (vsel_r == '0) ? own_id_r : ssender_r[vk];
  assign dis_vec  = node_dis(vec_snd, ids_r, dis_r);
  assign vec_act  = (vsel_r == '0) ? !dis_own : (svalid_r[vk] && !dis_vec);
  assign slot_idx = J_W'(in_slot);
  assign stg_idx  = J_W'(stg_cnt_r);

  // cost to the sender: route row of the last slot holding its id
  always_comb begin
    via_c = dvru_pkg::UNREACH;
    for (int i = 0; i < NODES; i++) begin
      if (ids_r[i] == vec_snd) via_c = rcost_r[i];
    end
  end

  // store slot search: same sender first, else first free slot
  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int k = STORE - 1; k >= 0; k--) begin
      if (svalid_r[k] && ssender_r[k] == stg_snd_r) begin
        hit = 1'b1;
        hit_idx = K_W'(k);
      end
      if (!svalid_r[k]) begin
        free = 1'b1;
        free_idx = K_W'(k);
      end
    end
  end

  // entry under relaxation: own direct vector or stored vector from memory
  assign e_id   = (vsel_r == '0) ? ids_r[cnt_r] : mem_id_q_r;
  assign e_cost = (vsel_r == '0) ? dcost_r[cnt_r] : mem_cost_q_r;
  assign sum    = {1'b0, e_cost} + {1'b0, via_r};

  assign mem_we    = (state_r == S_COPY);
  assign mem_waddr = {dst_r, cnt_r};
  assign mem_raddr = (state_r == S_VIA) ? {vk, J_W'(0)} : {vk, J_W'(cnt_r + J_W'(1))};

  always_comb begin
    ids_nxt = ids_r;
    dcost_nxt = dcost_r;
    nbr_nxt = nbr_r;
    dis_nxt = dis_r;
    rcost_nxt = rcost_r;
    nhop_nxt = nhop_r;
    svalid_nxt = svalid_r;
    ssender_nxt = ssender_r;
    stg_id_nxt = stg_id_r;
    stg_cost_nxt = stg_cost_r;
    stg_cnt_nxt = stg_cnt_r;
    stg_snd_nxt = stg_snd_r;
    own_id_nxt = own_id_r;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    vsel_nxt = vsel_r;
    dst_nxt = dst_r;
    st_nxt = st_r;
    via_nxt = via_r;
    snd_nxt = snd_r;
    ov_nxt = ov_r && !out_ready;
    o_st_nxt = o_st_r;
    o_dest_nxt = o_dest_r;
    o_cost_nxt = o_cost_r;
    o_nh_nxt = o_nh_r;
    o_fin_nxt = o_fin_r;

    if (cfg_valid && cfg_ready) own_id_nxt = cfg_own_id;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_mode)
            dvru_pkg::MODE_SET: begin
              // own node is always at cost zero; ack even for slots off the table
              if (int'(in_slot) < NODES) begin
                ids_nxt[slot_idx] = in_node_id;
                dcost_nxt[slot_idx] = (in_node_id == own_id_r) ? 16'd0 : in_cost;
                nbr_nxt[slot_idx] = in_neighbor;
              end
              ov_nxt = 1'b1;
              o_st_nxt = dvru_pkg::ST_OK;
              o_dest_nxt = in_node_id;
              o_cost_nxt = (in_node_id == own_id_r) ? 16'd0 : in_cost;
              o_nh_nxt = own_id_r;
              o_fin_nxt = 1'b1;
            end
            dvru_pkg::MODE_DIS: begin
              if (in_node_id == own_id_r) begin
                ov_nxt = 1'b1;
                o_st_nxt = dvru_pkg::ST_SELF;
                o_dest_nxt = 8'd0;
                o_cost_nxt = 16'd0;
                o_nh_nxt = 8'd0;
                o_fin_nxt = 1'b1;
              end else begin
                // only neighbor links get disabled
                for (int i = 0; i < NODES; i++) begin
                  if (ids_r[i] == in_node_id && nbr_r[i]) dis_nxt[i] = 1'b1;
                end
                st_nxt = dvru_pkg::ST_OK;
                state_nxt = S_INIT;
              end
            end
            dvru_pkg::MODE_VEC: begin
              if (int'(stg_cnt_r) < NODES) begin
                stg_id_nxt[stg_idx] = in_node_id;
                stg_cost_nxt[stg_idx] = in_cost;
                if (in_cost == 16'd0) stg_snd_nxt = in_node_id;
                stg_cnt_nxt = stg_cnt_r + C_W'(1);
              end
              if (in_last) state_nxt = S_COMMIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_COMMIT: begin
        if (stg_snd_r == own_id_r || dis_snd || (!hit && !free)) begin
          st_nxt = dvru_pkg::ST_DROP;
          for (int i = 0; i < NODES; i++) begin
            stg_id_nxt[i] = 8'd0;
            stg_cost_nxt[i] = dvru_pkg::UNREACH;
          end
          stg_cnt_nxt = '0;
          stg_snd_nxt = 8'd0;
          state_nxt = S_INIT;
        end else begin
          st_nxt = dvru_pkg::ST_OK;
          dst_nxt = hit ? hit_idx : free_idx;
          svalid_nxt[hit ? hit_idx : free_idx] = 1'b1;
          ssender_nxt[hit ? hit_idx : free_idx] = stg_snd_r;
          cnt_nxt = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // one staged entry into the vector memory per cycle
        cnt_nxt = cnt_r + J_W'(1);
        if (cnt_r == J_W'(NODES - 1)) begin
          for (int i = 0; i < NODES; i++) begin
            stg_id_nxt[i] = 8'd0;
            stg_cost_nxt[i] = dvru_pkg::UNREACH;
          end
          stg_cnt_nxt = '0;
          stg_snd_nxt = 8'd0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        // seed routes with the direct links
        for (int i = 0; i < NODES; i++) begin
          rcost_nxt[i] = dcost_r[i];
          nhop_nxt[i] = own_id_r;
        end
        vsel_nxt = '0;
        state_nxt = S_VIA;
      end
      S_VIA: begin
        if (vec_act) begin
          via_nxt = via_c;
          snd_nxt = vec_snd;
          cnt_nxt = '0;
          state_nxt = S_REL;
        end else if (vsel_r == J_W'(NODES - 1)) begin
          cnt_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          vsel_nxt = vsel_r + J_W'(1);
        end
      end
      S_REL: begin
        // one vector entry against every route row
        for (int i = 0; i < NODES; i++) begin
          if (ids_r[i] == e_id && sum < {1'b0, rcost_r[i]}) begin
            rcost_nxt[i] = sum[15:0];
            nhop_nxt[i] = snd_r;
          end
        end
        cnt_nxt = cnt_r + J_W'(1);
        if (cnt_r == J_W'(NODES - 1)) begin
          if (vsel_r == J_W'(NODES - 1)) begin
            cnt_nxt = '0;
            state_nxt = S_EMIT;
          end else begin
            vsel_nxt = vsel_r + J_W'(1);
            state_nxt = S_VIA;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          o_st_nxt = st_r;
          o_dest_nxt = ids_r[cnt_r];
          o_cost_nxt = rcost_r[cnt_r];
          o_nh_nxt = nhop_r[cnt_r];
          o_fin_nxt = (cnt_r == J_W'(NODES - 1));
          cnt_nxt = cnt_r + J_W'(1);
          if (cnt_r == J_W'(NODES - 1)) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        ids_r[i] <= 8'd0;
        dcost_r[i] <= dvru_pkg::UNREACH;
        rcost_r[i] <= dvru_pkg::UNREACH;
        nhop_r[i] <= 8'd0;
        stg_id_r[i] <= 8'd0;
        stg_cost_r[i] <= dvru_pkg::UNREACH;
      end
      nbr_r <= '0;
      dis_r <= '0;
      svalid_r <= '0;
      stg_cnt_r <= '0;
      stg_snd_r <= 8'd0;
      own_id_r <= 8'd0;
      state_r <= S_IDLE;
      cnt_r <= '0;
      vsel_r <= '0;
      st_r <= dvru_pkg::ST_OK;
      ov_r <= 1'b0;
    end else begin
      ids_r <= ids_nxt;
      dcost_r <= dcost_nxt;
      rcost_r <= rcost_nxt;
      nhop_r <= nhop_nxt;
      stg_id_r <= stg_id_nxt;
      stg_cost_r <= stg_cost_nxt;
      nbr_r <= nbr_nxt;
      dis_r <= dis_nxt;
      svalid_r <= svalid_nxt;
      stg_cnt_r <= stg_cnt_nxt;
      stg_snd_r <= stg_snd_nxt;
      own_id_r <= own_id_nxt;
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      vsel_r <= vsel_nxt;
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    ssender_r <= ssender_nxt;
    dst_r <= dst_nxt;
    via_r <= via_nxt;
    snd_r <= snd_nxt;
    o_st_r <= o_st_nxt;
    o_dest_r <= o_dest_nxt;
    o_cost_r <= o_cost_nxt;
    o_nh_r <= o_nh_nxt;
    o_fin_r <= o_fin_nxt;
  end

  // vector memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_id[mem_waddr] <= stg_id_r[cnt_r];
      mem_cost[mem_waddr] <= stg_cost_r[cnt_r];
    end
    mem_id_q_r <= mem_id[mem_raddr];
    mem_cost_q_r <= mem_cost[mem_raddr];
  end

  assign out_valid      = ov_r;
  assign out_status     = o_st_r;
  assign out_dest_id    = o_dest_r;
  assign out_route_cost = o_cost_r;
  assign out_next_hop   = o_nh_r;
  assign out_final_res  = o_fin_r;

endmodule

// ===== dv/distance_vector_route_update_checker.sv =====
// distance_vector_route_update_checker: watches the request and result channels,
// predicts route results and compares them; depends on dvru_pkg
module distance_vector_route_update_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_own_id,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_slot,
  input  logic [7:0]  in_node_id,
  input  logic [15:0] in_cost,
  input  logic        in_neighbor,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_dest_id,
  input  logic [15:0] out_route_cost,
  input  logic [7:0]  out_next_hop,
  input  logic        out_final_res,
  output int          fail_count,
  output int          pending_rows,
  output int          rows_seen
);

  localparam int N = 8;
  localparam int VSTORE = N - 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  dest;
    logic [15:0] rcost;
    logic [7:0]  hop;
    logic        fin;
  } route_row_t;

  route_row_t  expected_rows[$];
  logic [7:0]  self_id;
  logic [7:0]  tbl_id[N];
  logic [15:0] tbl_direct[N];
  logic        tbl_nbr[N];
  logic        tbl_off[N];
  logic [15:0] best[N];
  logic [7:0]  hop[N];
  logic        vec_ok[VSTORE];
  logic [7:0]  vec_from[VSTORE];
  logic [7:0]  vec_id[VSTORE][N];
  logic [15:0] vec_cost[VSTORE][N];
  logic [7:0]  stg_id[N];
  logic [15:0] stg_cost[N];
  int          stg_n;
  logic [7:0]  stg_from;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic bit is_off(input logic [7:0] id);
    for (int i = 0; i < N; i++) if (tbl_id[i] == id && tbl_off[i]) return 1;
    return 0;
  endfunction

  task automatic relax_with(input logic [7:0] from, input logic [7:0] ids[N],
                            input logic [15:0] costs[N]);
    logic [16:0] via;
    logic [16:0] sum;
    via = 17'(dvru_pkg::UNREACH);
    for (int i = 0; i < N; i++) if (tbl_id[i] == from) via = {1'b0, best[i]};
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++)
        if (tbl_id[i] == ids[j]) begin
          sum = {1'b0, costs[j]} + via;
          if (sum < {1'b0, best[i]}) begin
            best[i] = sum[15:0];
            hop[i] = from;
          end
        end
  endtask

  task automatic recompute_routes(input logic [1:0] st);
    route_row_t r;
    logic [7:0]  ids[N];
    logic [15:0] costs[N];
    for (int i = 0; i < N; i++) begin
      best[i] = tbl_direct[i];
      hop[i] = self_id;
    end
    if (!is_off(self_id)) relax_with(self_id, tbl_id, tbl_direct);
    for (int k = 0; k < VSTORE; k++)
      if (vec_ok[k] && !is_off(vec_from[k])) begin
        ids = vec_id[k];
        costs = vec_cost[k];
        relax_with(vec_from[k], ids, costs);
      end
    for (int i = 0; i < N; i++) begin
      r = route_row_t'{st, tbl_id[i], best[i], hop[i], i == N - 1};
      expected_rows.push_back(r);
    end
  endtask

  function automatic logic [1:0] store_vector();
    int dst;
    dst = -1;
    if (stg_from == self_id || is_off(stg_from)) return dvru_pkg::ST_DROP;
    for (int k = 0; k < VSTORE; k++)
      if (dst < 0 && vec_ok[k] && vec_from[k] == stg_from) dst = k;
    for (int k = 0; k < VSTORE; k++)
      if (dst < 0 && !vec_ok[k]) dst = k;
    if (dst < 0) return dvru_pkg::ST_DROP;
    vec_ok[dst] = 1;
    vec_from[dst] = stg_from;
    vec_id[dst] = stg_id;
    vec_cost[dst] = stg_cost;
    return dvru_pkg::ST_OK;
  endfunction

  task automatic predict_request();
    logic [15:0] c;
    logic [1:0]  st;
    case (in_mode)
      dvru_pkg::MODE_SET: begin
        c = (in_node_id == self_id) ? 16'd0 : in_cost;
        tbl_id[in_slot] = in_node_id;
        tbl_direct[in_slot] = c;
        tbl_nbr[in_slot] = in_neighbor;
        expected_rows.push_back(route_row_t'{dvru_pkg::ST_OK, in_node_id, c, self_id,
                                             1'b1});
      end
      dvru_pkg::MODE_DIS: begin
        if (in_node_id == self_id) begin
          expected_rows.push_back(route_row_t'{dvru_pkg::ST_SELF, 8'd0, 16'd0, 8'd0,
                                               1'b1});
        end else begin
          for (int i = 0; i < N; i++)
            if (tbl_id[i] == in_node_id && tbl_nbr[i]) tbl_off[i] = 1;
          recompute_routes(dvru_pkg::ST_OK);
        end
      end
      dvru_pkg::MODE_VEC: begin
        if (stg_n < N) begin
          stg_id[stg_n] = in_node_id;
          stg_cost[stg_n] = in_cost;
          if (in_cost == 0) stg_from = in_node_id;
          stg_n++;
        end
        if (in_last) begin
          st = store_vector();
          for (int i = 0; i < N; i++) begin
            stg_id[i] = 0;
            stg_cost[i] = dvru_pkg::UNREACH;
          end
          stg_n = 0;
          stg_from = 0;
          recompute_routes(st);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    route_row_t got;
    route_row_t want;
    if (!rst_n) begin
      self_id <= 0;
      stg_n <= 0;
      stg_from <= 0;
      for (int i = 0; i < N; i++) begin
        tbl_id[i] <= 0;
        tbl_direct[i] <= dvru_pkg::UNREACH;
        tbl_nbr[i] <= 0;
        tbl_off[i] <= 0;
        stg_id[i] <= 0;
        stg_cost[i] <= dvru_pkg::UNREACH;
      end
      for (int k = 0; k < VSTORE; k++) vec_ok[k] <= 0;
    end else begin
      if (cfg_valid && cfg_ready) self_id = cfg_own_id;
      if (out_valid && out_ready) begin
        got = route_row_t'{out_status, out_dest_id, out_route_cost, out_next_hop,
                           out_final_res};
        rows_seen++;
        if (expected_rows.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_rows.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
          if (got.dest != want.dest)
            report_mismatch($sformatf("dest_id %0d want %0d", got.dest, want.dest));
          if (got.rcost != want.rcost)
            report_mismatch($sformatf("route_cost %0d want %0d", got.rcost, want.rcost));
          if (got.hop != want.hop)
            report_mismatch($sformatf("next_hop %0d want %0d", got.hop, want.hop));
          if (got.fin != want.fin)
            report_mismatch($sformatf("final_res %0d want %0d", got.fin, want.fin));
        end
      end
      if (in_valid && in_ready) predict_request();
    end
    pending_rows = expected_rows.size();
  end

  initial begin
    fail_count = 0;
    rows_seen = 0;
    pending_rows = 0;
  end
endmodule

// ===== dv/distance_vector_route_update_test.sv =====
// distance_vector_route_update_test: stimulus and verdict for the route engine
// depends on dvru_pkg, distance_vector_route_update and its checker
module distance_vector_route_update_test;

  // mode code that the block leaves unused
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_own_id = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_mode = dvru_pkg::MODE_SET;
  logic [2:0]  in_slot = 0;
  logic [7:0]  in_node_id = 0;
  logic [15:0] in_cost = 0;
  logic        in_neighbor = 0;
  logic        in_last = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status;
  logic [7:0]  out_dest_id;
  logic [15:0] out_route_cost;
  logic [7:0]  out_next_hop;
  logic        out_final_res;
  int          fail_count;
  int          pending_rows;
  int          rows_seen;

  // idle percentages for each side, changed per phase
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_off = 0;
  int          sent = 0;
  logic [7:0]  own = 0;

  always #6 clk = ~clk;

  distance_vector_route_update dut (.*);

  distance_vector_route_update_checker chk (.*);

  // receiver: random stall, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic hold_receiver(input int cycles);
    hold_off = 1;
    repeat (cycles) @(posedge clk);
    hold_off = 0;
  endtask

  // one request, after a random idle gap; valid stays up until taken and
  // drops only in an idle gap or when the sender stops
  task automatic send_request(input logic [1:0] m, input logic [2:0] s,
                              input logic [7:0] id, input logic [15:0] c,
                              input logic nb, input logic lst);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= m;
    in_slot <= s;
    in_node_id <= id;
    in_cost <= c;
    in_neighbor <= nb;
    in_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic release_input();
    in_valid <= 0;
  endtask

  // wait for all expected rows, then let the recompute of a dropped item settle
  task automatic drain();
    release_input();
    while (pending_rows != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_own_id(input logic [7:0] v);
    drain();
    cfg_valid <= 1;
    cfg_own_id <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    own = v;
  endtask

  // picks ids from a small pool so that links, vectors and disables meet
  function automatic logic [7:0] pick_id();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 9));
  endfunction

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(5))
      0: return dvru_pkg::UNREACH;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // well-formed vector: sender entry with cost 0, then random entries
  task automatic send_vector(input logic [7:0] from);
    int n;
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++)
      if (k == 0)
        send_request(dvru_pkg::MODE_VEC, 3'($urandom), from, 16'd0, 1'($urandom),
                     n == 1);
      else
        send_request(dvru_pkg::MODE_VEC, 3'($urandom), pick_id(), pick_cost(),
                     1'($urandom), k == n - 1);
  endtask

  task automatic random_traffic(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40)
        send_request(dvru_pkg::MODE_SET, 3'($urandom), pick_id(), pick_cost(),
                     1'($urandom), 1'($urandom));
      else if (r < 55)
        send_request(dvru_pkg::MODE_DIS, 3'($urandom),
                     ($urandom_range(7) == 0) ? own : pick_id(), 16'($urandom),
                     1'($urandom), 1'($urandom));
      else if (r < 85)
        send_vector(pick_id());
      else
        send_request(dvru_pkg::MODE_VEC, 3'($urandom), pick_id(), 16'($urandom),
                     1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, self cases, disable rules, drops, overflow, store full
    write_own_id(8'd0);
    send_request(dvru_pkg::MODE_SET, 3'd0, 8'd0, 16'hFFFF, 1'b0, 1'b0);
    send_request(dvru_pkg::MODE_SET, 3'd7, 8'd255, 16'hFFFF, 1'b1, 1'b1);
    send_request(dvru_pkg::MODE_SET, 3'd1, 8'd1, 16'd0, 1'b1, 1'b0);
    send_request(dvru_pkg::MODE_SET, 3'd2, 8'd2, 16'd5, 1'b0, 1'b0);
    send_request(dvru_pkg::MODE_DIS, 3'd0, 8'd0, 16'd0, 1'b0, 1'b0);
    send_request(dvru_pkg::MODE_DIS, 3'd0, 8'd2, 16'd0, 1'b0, 1'b0);
    send_request(dvru_pkg::MODE_VEC, 3'd0, 8'd1, 16'd0, 1'b0, 1'b1);
    send_request(dvru_pkg::MODE_DIS, 3'd0, 8'd1, 16'd0, 1'b0, 1'b0);
    send_request(dvru_pkg::MODE_VEC, 3'd0, 8'd1, 16'd0, 1'b0, 1'b1);
    send_request(MODE_SPARE, 3'd5, 8'hAA, 16'h5555, 1'b1, 1'b1);
    for (int k = 0; k < 10; k++)
      send_request(dvru_pkg::MODE_VEC, 3'd0, 8'(k + 2), (k == 9) ? 16'd0 : 16'(k),
                   1'b0, k == 9);
    for (int v = 0; v < 8; v++)
      send_request(dvru_pkg::MODE_VEC, 3'd0, 8'(v + 20), 16'd0, 1'b0, 1'b1);

    write_own_id(8'd255);
    send_request(dvru_pkg::MODE_SET, 3'd3, 8'd255, 16'd77, 1'b1, 1'b0);
    send_request(dvru_pkg::MODE_DIS, 3'd0, 8'd255, 16'd0, 1'b0, 1'b0);

    // random phases with different idling; own id moves between phases
    write_own_id(8'd3);
    random_traffic(18);
    write_own_id(8'($urandom));
    send_idle = 61;
    random_traffic(15);
    send_idle = 0;
    recv_idle = 61;
    random_traffic(15);

    // receiver holds off while requests keep coming
    recv_idle = 0;
    fork
      hold_receiver(400);
      begin
        random_traffic(8);
        release_input();
        @(posedge clk);
      end
    join

    // sender pauses until every expected row is back
    while (pending_rows != 0) @(posedge clk);
    write_own_id(8'd5);
    send_idle = 13;
    recv_idle = 13;
    random_traffic(15);
    send_idle = 0;
    recv_idle = 0;
    random_traffic(12);

    drain();
    $display("sent %0d requests over several own ids, idle mixes and a long stall",
             sent);
    $display("checked %0d result rows", rows_seen);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #12000000;
    $display("FAILURE");
    $finish;
  end
endmodule
